[rtl/utf8_codepoint_decoder_assert.svh]
// assertion macros for the utf8 code point decoder
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// plain property check, clocked on clk and disabled in reset
`define UCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define UCD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define UCD_ASSERT(lbl, clk, rst, prop, msg)
`define UCD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define UCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/ucd_pkg.sv]
// types and constants shared by the utf8 code point decoder
`timescale 1ns / 1ps

package ucd_pkg;

   localparam int unsigned CP_WIDTH  = 21;
   localparam int unsigned DUE_WIDTH = 2;

   localparam logic [7:0] LEAD1_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;
   localparam logic [7:0] CONT_BITS  = 8'h3F;

   localparam logic [DUE_WIDTH-1:0] DUE_NONE  = 2'd0;
   localparam logic [DUE_WIDTH-1:0] DUE_ONE   = 2'd1;
   localparam logic [DUE_WIDTH-1:0] DUE_TWO   = 2'd2;
   localparam logic [DUE_WIDTH-1:0] DUE_THREE = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                stopped;
      logic                ends_text;
   } rsp_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0]  partial_value;
      logic [DUE_WIDTH-1:0] bytes_still_due;
      logic                 discarding;
   } dec_state_type;

endpackage

[rtl/ucd_step.sv]
// decode logic for one byte: next decoder state and optional result
`timescale 1ns / 1ps

module ucd_step
   import ucd_pkg::*;
(
   input  dec_state_type state_cur,
   input  req_type       item,
   output dec_state_type state_next,
   output logic          result_valid,
   output rsp_type       result
);

   logic [7:0]          b;
   logic                last;
   logic [CP_WIDTH-1:0] shifted;

   assign b       = item.data_byte;
   assign last    = item.end_of_text;
   assign shifted = {state_cur.partial_value[CP_WIDTH-7:0], b[5:0]};

   always_comb begin
      state_next   = state_cur;
      result_valid = 1'b0;
      result       = '0;
      priority if (state_cur.discarding) begin
         if (last) begin
            state_next = '0;
         end
      end else if (state_cur.bytes_still_due == DUE_NONE) begin
         priority if ((b & LEAD1_MASK) == 8'h00) begin
            state_next        = '0;
            result_valid      = 1'b1;
            result.code_point = {{(CP_WIDTH-8){1'b0}}, b};
            result.ends_text  = last;
         end else if ((b & LEAD2_MASK) == LEAD2_CODE ||
                      (b & LEAD3_MASK) == LEAD3_CODE ||
                      (b & LEAD4_MASK) == LEAD4_CODE) begin
            if (last) begin
               // lead byte with no room left for its continuation
               state_next       = '0;
               result_valid     = 1'b1;
               result.stopped   = 1'b1;
               result.ends_text = 1'b1;
            end else begin
               state_next.discarding = 1'b0;
               priority if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                  state_next.partial_value   = {{(CP_WIDTH-8){1'b0}}, b & LEAD2_BITS};
                  state_next.bytes_still_due = DUE_ONE;
               end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                  state_next.partial_value   = {{(CP_WIDTH-8){1'b0}}, b & LEAD3_BITS};
                  state_next.bytes_still_due = DUE_TWO;
               end else begin
                  state_next.partial_value   = {{(CP_WIDTH-8){1'b0}}, b & LEAD4_BITS};
                  state_next.bytes_still_due = DUE_THREE;
               end
            end
         end else begin
            // bad lead byte
            state_next            = '0;
            state_next.discarding = ~last;
            result_valid          = 1'b1;
            result.stopped        = 1'b1;
            result.ends_text      = 1'b1;
         end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
         state_next            = '0;
         state_next.discarding = ~last;
         result_valid          = 1'b1;
         result.stopped        = 1'b1;
         result.ends_text      = 1'b1;
      end else if (state_cur.bytes_still_due == DUE_ONE) begin
         state_next        = '0;
         result_valid      = 1'b1;
         result.code_point = shifted;
         result.ends_text  = last;
      end else if (last) begin
         // text ends mid-form
         state_next       = '0;
         result_valid     = 1'b1;
         result.stopped   = 1'b1;
         result.ends_text = 1'b1;
      end else begin
         state_next.partial_value   = shifted;
         state_next.bytes_still_due = state_cur.bytes_still_due - DUE_ONE;
      end
   end

endmodule

[rtl/utf8_codepoint_decoder.sv]
// top level of the utf8 code point decoder: input register, decode, result register
`timescale 1ns / 1ps

// Decodes a UTF-8 text presented one byte per item, end_of_text set on its
// last byte, into 21-bit code points. Every byte is registered on entry,
// decoded against the running state combinationally and its result (if any)
// lands in a one-entry result register, so one byte is taken every cycle but
// when a byte with a result waits for room in that register. Bytes that
// complete no code point give no result. A bad lead or continuation byte, or a
// text that ends mid-form, gives one result with stopped and ends_text set and
// code_point zero, and the remaining bytes of that text are dropped. Overlong
// forms and surrogates pass unchecked. Back-pressure on the result side stalls
// only bytes that would produce a result.
module utf8_codepoint_decoder
   import ucd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

`include "utf8_codepoint_decoder_assert.svh"

   logic          in_valid_ff, in_valid_in;
   req_type       in_item_ff, in_item_in;
   dec_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_item_ff, out_item_in;

   dec_state_type step_state;
   logic          step_valid;
   rsp_type       step_rsp;
   logic          out_room;
   logic          advance;

   ucd_step u_step (
      .state_cur    (state_ff),
      .item         (in_item_ff),
      .state_next   (step_state),
      .result_valid (step_valid),
      .result       (step_rsp)
   );

   assign out_room  = ~out_valid_ff | rsp_ready;
   // a byte that yields nothing never waits for the result side
   assign advance   = in_valid_ff & (out_room | ~step_valid);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = req_payload;
      end
   end

   assign state_in = advance ? step_state : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance && step_valid) begin
         out_valid_in = 1'b1;
         out_item_in  = step_rsp;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   `UCD_ASSERT_IMPL(a_stop_shape, clock, reset, rsp_valid && rsp_payload.stopped, rsp_payload.code_point == '0 && rsp_payload.ends_text, "stop item must carry zero code point and ends_text")
   `UCD_ASSERT_IMPL(a_discard_clean, clock, reset, state_ff.discarding, state_ff.bytes_still_due == DUE_NONE && state_ff.partial_value == '0, "discarding with partial form held")
   `UCD_ASSERT_NEXT(a_fresh_after_end, clock, reset, advance && in_item_ff.end_of_text, state_ff == '0, "decoder state not cleared after last byte of text")
   `UCD_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "pending result item lost or changed")
   `UCD_ASSERT_IMPL(a_no_overwrite, clock, reset, advance && step_valid, out_room, "result register overwritten while full")

endmodule

[verif/utf8_codepoint_decoder_tb.sv]
// self-checking testbench for the utf8 code point decoder
`timescale 1ns / 1ps

module utf8_codepoint_decoder_tb;
   import ucd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned PHASE_BYTES   = 250;
   localparam int unsigned TAIL_CYCLES   = 10;
   localparam int unsigned DIRECTED_LEN  = 26;

   // {data_byte, end_of_text}
   localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
      {8'h00, 1'b1},                                     // smallest ascii ends a text
      {8'h7F, 1'b0},                                     // largest ascii
      {8'hC0, 1'b0}, {8'h80, 1'b1},                      // overlong zero
      {8'hDF, 1'b0}, {8'hBF, 1'b0},                      // top of two byte form
      {8'hED, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b0},       // surrogate passes
      {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1}, // 0x1fffff
      {8'h80, 1'b0},                                     // stray continuation as lead
      {8'h41, 1'b0}, {8'hFF, 1'b1},                      // dropped up to end of text
      {8'hF8, 1'b1},                                     // bad lead on last byte
      {8'hC3, 1'b0}, {8'h41, 1'b0}, {8'h42, 1'b1},       // bad continuation, then dropped
      {8'hE2, 1'b0}, {8'h82, 1'b1},                      // text ends mid form
      {8'hF0, 1'b1},                                     // lone lead ends text
      {8'hC3, 1'b0}, {8'hC3, 1'b1},                      // bad continuation on last byte
      {8'h7F, 1'b1}                                      // fresh start afterwards
   };

   // tracks decoder state and holds the code points still owed by the block
   class cp_tracker;
      rsp_type              owed_points[$];
      logic [CP_WIDTH-1:0]  partial_value;
      logic [DUE_WIDTH-1:0] bytes_due;
      bit                   discarding;
      int unsigned          mismatches;

      function new();
         start_fresh();
         mismatches = 0;
      endfunction

      function void start_fresh();
         partial_value = '0;
         bytes_due     = DUE_NONE;
         discarding    = 1'b0;
      endfunction

      function void add_point(logic [CP_WIDTH-1:0] cp, logic stop, logic last);
         rsp_type item;
         item.code_point = stop ? '0 : cp;
         item.stopped    = stop;
         item.ends_text  = last;
         owed_points = {owed_points, item};
      endfunction

      function void stop_text(logic last_byte);
         start_fresh();
         discarding = !last_byte;
         add_point('0, 1'b1, 1'b1);
      endfunction

      function void decode_byte(req_type item);
         logic [7:0]          b;
         logic                last;
         logic [CP_WIDTH-1:0] cp;
         b    = item.data_byte;
         last = item.end_of_text;
         if (discarding) begin
            if (last) start_fresh();
            return;
         end
         if (bytes_due == DUE_NONE) begin
            if ((b & LEAD1_MASK) == '0) begin
               start_fresh();
               add_point(CP_WIDTH'(b), 1'b0, last);
               return;
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
               partial_value = CP_WIDTH'(b & LEAD2_BITS);
               bytes_due     = DUE_ONE;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
               partial_value = CP_WIDTH'(b & LEAD3_BITS);
               bytes_due     = DUE_TWO;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
               partial_value = CP_WIDTH'(b & LEAD4_BITS);
               bytes_due     = DUE_THREE;
            end else begin
               stop_text(last);
               return;
            end
            if (last) stop_text(1'b1);
            return;
         end
         if ((b & CONT_MASK) != CONT_CODE) begin
            stop_text(last);
            return;
         end
         partial_value = {partial_value[CP_WIDTH-7:0], b[5:0]};
         bytes_due     = bytes_due - 1'b1;
         if (bytes_due == DUE_NONE) begin
            cp = partial_value;
            start_fresh();
            add_point(cp, 1'b0, last);
         end else if (last) begin
            stop_text(1'b1);
         end
      endfunction

      function void check_point(rsp_type got);
         rsp_type want;
         if (owed_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: cp %h stopped %b ends_text %b",
                        got.code_point, got.stopped, got.ends_text);
            return;
         end
         want = owed_points.pop_front();
         if (got.code_point !== want.code_point || got.stopped !== want.stopped ||
             got.ends_text !== want.ends_text) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected cp %h stopped %b ends_text %b, ",
                         "got cp %h stopped %b ends_text %b"},
                        want.code_point, want.stopped, want.ends_text,
                        got.code_point, got.stopped, got.ends_text);
         end
      endfunction

      function int unsigned outstanding();
         return owed_points.size();
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_ready   = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_payload;

   cp_tracker   tracker;
   int unsigned idle_pct       = 0;
   int unsigned stall_pct      = 0;
   int unsigned bytes_accepted = 0;
   int unsigned cycle_count    = 0;
   logic [7:0]  text_buf[$];

   utf8_codepoint_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.decode_byte(req_payload);
            bytes_accepted++;
         end
         if (rsp_valid && rsp_ready) tracker.check_point(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays up after acceptance
   task automatic send_byte(input logic [7:0] value, input logic last);
      int unsigned target;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid   <= 1'b0;
         req_payload <= 9'($urandom);
         @(negedge clock);
      end
      target = bytes_accepted + 1;
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, end_of_text: last};
      do @(negedge clock); while (bytes_accepted != target);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.outstanding() != 0);
   endtask

   // one well-formed form of len bytes with random content bits
   function automatic void append_form(int unsigned len);
      case (len)
         1: text_buf = {text_buf, 8'($urandom) & ~LEAD1_MASK};
         2: text_buf = {text_buf, LEAD2_CODE | (8'($urandom) & LEAD2_BITS)};
         3: text_buf = {text_buf, LEAD3_CODE | (8'($urandom) & LEAD3_BITS)};
         default: text_buf = {text_buf, LEAD4_CODE | (8'($urandom) & LEAD4_BITS)};
      endcase
      repeat (len - 1) text_buf = {text_buf, CONT_CODE | (8'($urandom) & CONT_BITS)};
   endfunction

   task automatic send_random_text();
      int unsigned pick;
      int unsigned count;
      int unsigned spot;
      pick = $urandom_range(99);
      text_buf.delete();
      if (pick < 15) begin
         // raw noise with scattered end flags
         count = $urandom_range(1, 6);
         repeat (count) send_byte(8'($urandom), $urandom_range(3) == 0);
         return;
      end
      count = $urandom_range(1, 6);
      repeat (count) append_form($urandom_range(1, 4));
      if (pick < 23) begin
         spot = $urandom_range(text_buf.size() - 1);
         text_buf[spot] = 8'($urandom);
      end else if (pick < 30 && text_buf.size() > 1) begin
         // cut the text short, often mid form
         count = $urandom_range(1, text_buf.size() - 1);
         repeat (count) void'(text_buf.pop_back());
      end
      foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   initial begin
      int unsigned phase_start;
      tracker = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_byte(DIRECTED[i][8:1], DIRECTED[i][0]);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         phase_start = bytes_accepted;
         while (bytes_accepted - phase_start < PHASE_BYTES) send_random_text();
         // hold off until every owed code point is back
         wait_drained();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[utf8_codepoint_decoder.f]
+incdir+rtl
rtl/ucd_pkg.sv
rtl/ucd_step.sv
rtl/utf8_codepoint_decoder.sv
verif/utf8_codepoint_decoder_tb.sv
